### design/nggp_pkg.sv
package nggp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] PREFIX_LEN = 3'd7;

  localparam logic [3:0] FLD_LAT      = 4'd1;
  localparam logic [3:0] FLD_LAT_HEMI = 4'd2;
  localparam logic [3:0] FLD_LON      = 4'd3;
  localparam logic [3:0] FLD_LON_HEMI = 4'd4;
  localparam logic [3:0] FLD_SATS     = 4'd6;
  localparam logic [3:0] FLD_HDOP     = 4'd7;
  localparam logic [3:0] FLD_ALT      = 4'd8;
  localparam logic [3:0] FLD_MAX      = 4'd15;

  localparam logic [13:0] HDOP_NONE = 14'd9900;
  localparam logic [13:0] HDOP_MAX  = 14'd9999;
  localparam logic [26:0] ALT_MAX   = 27'd100000000;
  localparam logic [31:0] LAT_MAX   = 32'd1000000000;
  localparam logic [31:0] LON_MAX   = 32'd2000000000;

  typedef enum logic [1:0] {
    HEMI_NONE,
    HEMI_MATCH,
    HEMI_OTHER
  } hemi_e;

  typedef struct packed {
    logic       valid;
    logic       emit;
    logic       do_field;
    logic [3:0] field;
    logic       neg;
    logic       hemi_neg;
    logic       seen_digit;
  } tok_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h24;
      3'd1: ch = 8'h47;
      3'd2: ch = 8'h50;
      3'd3: ch = 8'h47;
      3'd4: ch = 8'h47;
      3'd5: ch = 8'h41;
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

### design/nmea_gga_sentence_parser.sv
// Channel | Beat                 | Handshake
// in      | char_in_i            | in_valid_i / in_stall_o
// out     | lat_e7_o .. sample_* | out_valid_o / out_stall_i
//
// One character is taken every cycle while the output side is not stalled.
// A sample appears once the CR or LF ending its line has passed the lexer token register,
// tok2_q, tok3_q, tok4_q and the output registers; the coordinate conversion pipeline
// (divide by 100, scale, divide by 60) sets this depth.
// Reset clears the parser, the held values and the sentence counter.
// A stalled result freezes the whole pipeline and raises in_stall_o.
module nmea_gga_sentence_parser #(
  parameter int FRAC_DIGITS_KEPT = 5,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [30:0] lat_e7_o,
  output logic signed [31:0] lon_e7_o,
  output logic [7:0]         sat_count_o,
  output logic [13:0]        hdop_centi_o,
  output logic signed [27:0] alt_cm_o,
  output logic [31:0]        sample_index_o
);
  import nggp_pkg::*;

  localparam int FW = $clog2(10 ** FRAC_DIGITS_KEPT);
  localparam int RSCALE = 10 ** (7 - FRAC_DIGITS_KEPT);

  logic adv;
  logic out_valid_q;

  tok_t          tok1, tok2_q, tok3_q, tok4_q;
  logic [31:0]   i1, i2_q;
  logic [FW-1:0] f1, f2_q;
  logic [6:0]    c1;
  logic [25:0]   deg_d, deg2_q, deg3_q;
  logic [27:0]   small_d, small2_q, small3_q, small4_q;
  logic [29:0]   n_d, n3_q, n4_q;
  logic [24:0]   q0_d, q04_q;
  logic [49:0]   degs_d, degs4_q;

  logic [38:0]   v100;
  logic [7:0]    sats_v;
  logic [13:0]   hdop_v;
  logic [26:0]   alt_mag;
  logic [6:0]    mins;
  logic [29:0]   rem;
  logic [24:0]   qfin;
  logic [49:0]   cmag;
  logic [31:0]   lim, mag;

  logic signed [30:0] lat_q, lat_d;
  logic signed [31:0] lon_q, lon_d;
  logic [7:0]         sats_q, sats_d;
  logic [13:0]        hdop_q, hdop_d;
  logic signed [27:0] alt_q, alt_d;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [63:0]        count_ext;
  logic               fire;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  nggp_lex #(
    .FRAC_DIGITS_KEPT(FRAC_DIGITS_KEPT),
    .FW(FW)
  ) u_lex (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .take_i  (in_valid_i),
    .char_i  (char_in_i),
    .tok_o   (tok1),
    .int_o   (i1),
    .frac_o  (f1),
    .centi_o (c1)
  );

  always_comb begin
    deg_d   = 26'((64'(i1) * 64'h51EB851F) >> 37);
    v100    = 39'(i1) * 39'd100 + 39'(c1);
    sats_v  = (!tok1.seen_digit || (tok1.neg && (i1 != 32'd0))) ? 8'd0 :
              ((i1 > 32'd255) ? 8'hFF : i1[7:0]);
    if (!tok1.seen_digit) begin
      hdop_v = HDOP_NONE;
    end else if (tok1.neg && (v100 != 39'd0)) begin
      hdop_v = 14'd0;
    end else begin
      hdop_v = (v100 > 39'(HDOP_MAX)) ? HDOP_MAX : v100[13:0];
    end
    alt_mag = (v100 > 39'(ALT_MAX)) ? ALT_MAX : v100[26:0];
    case (tok1.field)
      FLD_SATS: small_d = 28'(sats_v);
      FLD_HDOP: small_d = 28'(hdop_v);
      FLD_ALT: begin
        if (!tok1.seen_digit) begin
          small_d = '0;
        end else begin
          small_d = tok1.neg ? -28'(alt_mag) : 28'(alt_mag);
        end
      end
      default: small_d = '0;
    endcase
  end

  always_comb begin
    mins = 7'(i2_q - 32'(deg2_q) * 32'd100);
    n_d  = 30'(64'(mins) * 64'd10000000 + 64'(f2_q) * 64'(RSCALE) + 64'd30);
  end

  always_comb begin
    q0_d   = 25'((64'(n3_q) * 64'd1145324612) >> 36);
    degs_d = 50'(deg3_q) * 50'd10000000;
  end

  always_comb begin
    rem  = n4_q - 30'(q04_q) * 30'd60;
    qfin = (rem >= 30'd60) ? q04_q + 25'd1 : q04_q;
    cmag = degs4_q + 50'(qfin);
    lim  = (tok4_q.field == FLD_LAT) ? LAT_MAX : LON_MAX;
    mag  = (cmag > 50'(lim)) ? lim : cmag[31:0];
    fire = tok4_q.valid && tok4_q.do_field;
    lat_d = lat_q; lon_d = lon_q; sats_d = sats_q; hdop_d = hdop_q; alt_d = alt_q;
    if (fire) begin
      case (tok4_q.field)
        FLD_LAT: lat_d = tok4_q.neg ? -31'(mag) : 31'(mag);
        FLD_LAT_HEMI: begin
          if (tok4_q.hemi_neg) begin
            lat_d = -lat_q;
          end
        end
        FLD_LON: lon_d = tok4_q.neg ? -mag : mag;
        FLD_LON_HEMI: begin
          if (tok4_q.hemi_neg) begin
            lon_d = -lon_q;
          end
        end
        FLD_SATS: sats_d = small4_q[7:0];
        FLD_HDOP: hdop_d = small4_q[13:0];
        FLD_ALT: alt_d = small4_q;
        default: lat_d = lat_q;
      endcase
    end
    count_ext = 64'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0; tok3_q <= '0; tok4_q <= '0;
      lat_q <= '0; lon_q <= '0; sats_q <= '0; hdop_q <= '0; alt_q <= '0;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      tok2_q <= tok1; tok3_q <= tok2_q; tok4_q <= tok3_q;
      lat_q <= lat_d; lon_q <= lon_d; sats_q <= sats_d; hdop_q <= hdop_d;
      alt_q <= alt_d;
      out_valid_q <= tok4_q.valid && tok4_q.emit;
      if (tok4_q.valid && tok4_q.emit) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i2_q <= i1; f2_q <= f1; deg2_q <= deg_d; small2_q <= small_d;
      deg3_q <= deg2_q; n3_q <= n_d; small3_q <= small2_q;
      q04_q <= q0_d; n4_q <= n3_q; degs4_q <= degs_d; small4_q <= small3_q;
      if (tok4_q.valid && tok4_q.emit) begin
        lat_e7_o       <= lat_d;
        lon_e7_o       <= lon_d;
        sat_count_o    <= sats_d;
        hdop_centi_o   <= hdop_d;
        alt_cm_o       <= alt_d;
        sample_index_o <= count_ext[31:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tok4_q.valid && tok4_q.emit) |=>
      (count_q == COUNT_WIDTH'($past(count_q) + 1'b1)))
    else $error("sentence counter did not advance on an emitted sample");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lat_q <= 31'sd1000000000) && (lat_q >= -31'sd1000000000))
    else $error("held latitude out of range");

  a_hdop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdop_q <= HDOP_MAX)
    else $error("held HDOP out of range");

  a_emit_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok1.valid && tok1.emit) |-> (tok1.field >= FLD_ALT))
    else $error("sample emitted for a short line");

endmodule

### design/nggp_lex.sv
module nggp_lex #(
  parameter int FRAC_DIGITS_KEPT = 5,
  parameter int FW = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           take_i,
  input  logic [7:0]     char_i,
  output nggp_pkg::tok_t tok_o,
  output logic [31:0]    int_o,
  output logic [FW-1:0]  frac_o,
  output logic [6:0]     centi_o
);
  import nggp_pkg::*;

  logic [2:0]    pp_q, pp_d;
  logic [3:0]    fi_q, fi_d;
  logic          lf_q, lf_d;
  logic          neg_q, neg_d;
  logic          sp_q, sp_d;
  logic          sd_q, sd_d;
  logic          fne_q, fne_d;
  logic          nd_q, nd_d;
  hemi_e         hemi_q, hemi_d;
  logic [31:0]   int_q, int_d;
  logic [FW-1:0] fs_q, fs_d;
  logic [6:0]    ce_q, ce_d;
  logic [2:0]    fd_q, fd_d;
  tok_t          tok_q, tok_d;
  logic [31:0]   tint_q;
  logic [FW-1:0] tfs_q;
  logic [6:0]    tce_q;

  logic          is_digit;
  logic [3:0]    dig;
  logic [35:0]   int_mul;
  logic [27:0]   frac_add;
  logic [7:0]    target;
  logic          line_ok;

  always_comb begin
    is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    dig      = 4'(char_i - CH_ZERO);
    int_mul  = 36'(int_q) * 36'd10 + 36'(dig);
    frac_add = 28'(dig) * 28'(pow10(3'(FRAC_DIGITS_KEPT - 1) - fd_q));
    target   = (fi_q == FLD_LAT_HEMI) ? CH_S : CH_W;
    line_ok  = !lf_q && (pp_q == PREFIX_LEN) &&
               ((fi_q > FLD_ALT) || ((fi_q == FLD_ALT) && fne_q));
  end

  always_comb begin
    pp_d = pp_q; fi_d = fi_q; lf_d = lf_q; neg_d = neg_q; sp_d = sp_q;
    sd_d = sd_q; fne_d = fne_q; nd_d = nd_q; hemi_d = hemi_q;
    int_d = int_q; fs_d = fs_q; ce_d = ce_q; fd_d = fd_q;
    tok_d = '0;
    tok_d.field      = fi_q;
    tok_d.neg        = neg_q;
    tok_d.hemi_neg   = (hemi_q == HEMI_MATCH);
    tok_d.seen_digit = sd_q;
    if (take_i) begin
      if ((char_i == CH_CR) || (char_i == CH_LF)) begin
        tok_d.valid    = line_ok;
        tok_d.emit     = line_ok;
        tok_d.do_field = line_ok && (fi_q == FLD_ALT);
        pp_d = '0; fi_d = '0; lf_d = 1'b0;
        neg_d = 1'b0; sp_d = 1'b0; sd_d = 1'b0; fne_d = 1'b0; nd_d = 1'b0;
        hemi_d = HEMI_NONE; int_d = '0; fs_d = '0; ce_d = '0; fd_d = '0;
      end else if (lf_q) begin
        lf_d = 1'b1;
      end else if (pp_q < PREFIX_LEN) begin
        if (char_i == prefix_char(pp_q)) begin
          pp_d = pp_q + 3'd1;
        end else begin
          lf_d = 1'b1;
        end
      end else if (char_i == CH_COMMA) begin
        if (((fi_q == FLD_LAT) || (fi_q == FLD_LON)) && !sd_q) begin
          lf_d = 1'b1;
        end else begin
          tok_d.valid    = 1'b1;
          tok_d.do_field = 1'b1;
        end
        if (fi_q < FLD_MAX) begin
          fi_d = fi_q + 4'd1;
        end
        neg_d = 1'b0; sp_d = 1'b0; sd_d = 1'b0; fne_d = 1'b0; nd_d = 1'b0;
        hemi_d = HEMI_NONE; int_d = '0; fs_d = '0; ce_d = '0; fd_d = '0;
      end else begin
        hemi_d = ((hemi_q == HEMI_NONE) && (char_i == target)) ? HEMI_MATCH : HEMI_OTHER;
        if (!nd_q) begin
          if (is_digit) begin
            sd_d = 1'b1;
            if (!sp_q) begin
              int_d = (int_mul > 36'h0FFFFFFFF) ? 32'hFFFFFFFF : int_mul[31:0];
            end else if (32'(fd_q) < 32'(FRAC_DIGITS_KEPT)) begin
              fs_d = fs_q + FW'(frac_add);
              if (fd_q == 3'd0) begin
                ce_d = 7'(dig) * 7'd10;
              end else if (fd_q == 3'd1) begin
                ce_d = ce_q + 7'(dig);
              end
              fd_d = fd_q + 3'd1;
            end
          end else if ((char_i == CH_DOT) && !sp_q) begin
            sp_d = 1'b1;
          end else if (((char_i == CH_MINUS) || (char_i == CH_PLUS)) && !fne_q) begin
            neg_d = (char_i == CH_MINUS);
          end else begin
            nd_d = 1'b1;
          end
        end
        fne_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q <= '0; fi_q <= '0; lf_q <= 1'b0; neg_q <= 1'b0; sp_q <= 1'b0;
      sd_q <= 1'b0; fne_q <= 1'b0; nd_q <= 1'b0; hemi_q <= HEMI_NONE;
      int_q <= '0; fs_q <= '0; ce_q <= '0; fd_q <= '0;
      tok_q <= '0;
    end else if (adv_i) begin
      pp_q <= pp_d; fi_q <= fi_d; lf_q <= lf_d; neg_q <= neg_d; sp_q <= sp_d;
      sd_q <= sd_d; fne_q <= fne_d; nd_q <= nd_d; hemi_q <= hemi_d;
      int_q <= int_d; fs_q <= fs_d; ce_q <= ce_d; fd_q <= fd_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tint_q <= int_q;
      tfs_q  <= fs_q;
      tce_q  <= ce_q;
    end
  end

  assign tok_o   = tok_q;
  assign int_o   = tint_q;
  assign frac_o  = tfs_q;
  assign centi_o = tce_q;

endmodule
